>>> rtl/idmr_pkg.sv
`default_nettype none
package idmr_pkg;

    // depth of the queue between the accumulate front and the requantize back
    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_OFF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_OFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_HI  = 3'd5;

    localparam logic signed [8:0]  RST_IN_OFF  = 9'sd0;
    localparam logic signed [7:0]  RST_OUT_OFF = 8'sd0;
    localparam logic signed [31:0] RST_MULT    = 32'sh4000_0000;
    localparam logic signed [5:0]  RST_EXPO    = 6'sd0;
    localparam logic signed [7:0]  RST_ACT_LO  = -8'sd128;
    localparam logic signed [7:0]  RST_ACT_HI  = 8'sd127;

    localparam logic signed [31:0] WORD_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX   = 32'sh7fff_ffff;
    localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0000_4000_0000;

    typedef struct packed {
        logic signed [8:0]  in_off;
        logic signed [7:0]  out_off;
        logic signed [31:0] mult;
        logic signed [5:0]  expo;
        logic signed [7:0]  act_lo;
        logic signed [7:0]  act_hi;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
        logic afull;   // one slot left
    } t_q_status;

endpackage
`default_nettype wire

>>> rtl/int8_dense_mac_requantize_top.sv
`default_nettype none
// int8 dense layer unit: multiply-accumulate with requantization to int8.
//
// Input channel (i_valid / o_stall): one beat per activation/weight pair.
// The beat with i_last set also carries the unit's bias and closes the
// dot product; a result beat follows on the output channel
// (o_valid / i_stall) and the accumulator starts again from zero.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): write register
// i_cfg_index with i_cfg_data while no beats are in flight.
//
// Throughput: one input beat per cycle while o_stall is low, set by the
// single MAC in the front. A last beat that finds nothing waiting in the
// queue ahead of it passes one MAC stage, the queue write, then the
// multiply, rounding and shift/clamp stages in the back to o_valid.
// The front and back are split by a QUEUE_DEPTH-entry queue: when the
// receiver stalls, results back up into the queue and o_stall rises once
// it is full, or one slot short of full while a last beat is about to be
// written; non-last beats keep flowing until then.
// Reset clears the accumulator, the queue and all valids, and restores
// the register defaults (multiplier 2^30, clamps -128..127).
module int8_dense_mac_requantize_top #(
    parameter int QUEUE_DEPTH = idmr_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [7:0]              i_activation,
    input  wire logic signed [7:0]              i_weight,
    input  wire logic signed [31:0]             i_bias,
    input  wire logic                           i_last,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [7:0]                   o_result,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [idmr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [idmr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    idmr_pkg::t_cfg      r_cfg;
    idmr_pkg::t_q_status w_q_status;
    logic                w_push;
    logic [31:0]         w_push_data;
    logic                w_pop;
    logic [31:0]         w_q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_off  <= idmr_pkg::RST_IN_OFF;
            r_cfg.out_off <= idmr_pkg::RST_OUT_OFF;
            r_cfg.mult    <= idmr_pkg::RST_MULT;
            r_cfg.expo    <= idmr_pkg::RST_EXPO;
            r_cfg.act_lo  <= idmr_pkg::RST_ACT_LO;
            r_cfg.act_hi  <= idmr_pkg::RST_ACT_HI;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                idmr_pkg::CFG_IN_OFF:  r_cfg.in_off  <= i_cfg_data[8:0];
                idmr_pkg::CFG_OUT_OFF: r_cfg.out_off <= i_cfg_data[7:0];
                idmr_pkg::CFG_MULT:    r_cfg.mult    <= i_cfg_data[31:0];
                idmr_pkg::CFG_EXPO:    r_cfg.expo    <= i_cfg_data[5:0];
                idmr_pkg::CFG_ACT_LO:  r_cfg.act_lo  <= i_cfg_data[7:0];
                idmr_pkg::CFG_ACT_HI:  r_cfg.act_hi  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    idmr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_status   (w_q_status),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_activation (i_activation),
        .i_weight     (i_weight),
        .i_bias       (i_bias),
        .i_last       (i_last),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    idmr_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (32)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_data),
        .i_pop    (w_pop),
        .o_data   (w_q_data),
        .o_status (w_q_status)
    );

    idmr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (w_q_status.empty),
        .i_data   (w_q_data),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!w_q_status.full || w_pop))
        else $error("queue overflow");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("queue underflow");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> o_stall)
        else $error("input not stalled with full queue");

    a_push_no_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_status.afull && w_push && !w_pop) |=> w_q_status.full)
        else $error("queue count lost a beat");

endmodule
`default_nettype wire

>>> rtl/idmr_front.sv
`default_nettype none
module idmr_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire idmr_pkg::t_cfg     i_cfg,
    input  wire idmr_pkg::t_q_status i_q_status,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [7:0]  i_activation,
    input  wire logic signed [7:0]  i_weight,
    input  wire logic signed [31:0] i_bias,
    input  wire logic               i_last,
    output logic                    o_push,
    output logic [31:0]             o_push_data
);

    logic               r_s1_valid;
    logic               r_s1_last;
    logic signed [17:0] r_s1_prod;
    logic [31:0]        r_s1_bias;
    logic [31:0]        r_acc;

    logic               w_accept;
    logic signed [9:0]  w_act_off;
    logic signed [17:0] w_prod;
    logic [31:0]        w_sum;

    // a last beat in stage 1 will take a slot next edge; keep room for the new beat too
    assign o_stall  = i_q_status.full ||
                      (i_q_status.afull && r_s1_valid && r_s1_last);
    assign w_accept = i_valid && !o_stall;

    assign w_act_off = 10'(i_activation) + 10'(i_cfg.in_off);
    assign w_prod    = 18'(w_act_off) * 18'(i_weight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_prod <= w_prod;
            r_s1_bias <= i_bias;
            r_s1_last <= i_last;
        end
    end

    assign w_sum       = r_acc + 32'(r_s1_prod);
    assign o_push      = r_s1_valid && r_s1_last;
    assign o_push_data = w_sum + r_s1_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_s1_valid) begin
            r_acc <= r_s1_last ? '0 : w_sum;
        end
    end

endmodule
`default_nettype wire

>>> rtl/idmr_queue.sv
`default_nettype none
module idmr_queue #(
    parameter int DEPTH = idmr_pkg::QUEUE_DEPTH,
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output idmr_pkg::t_q_status   o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] AFULL_CNT = CNT_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    assign o_data         = r_mem[r_head];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.afull = (r_count == AFULL_CNT);

endmodule
`default_nettype wire

>>> rtl/idmr_back.sv
`default_nettype none
module idmr_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire idmr_pkg::t_cfg i_cfg,
    input  wire logic        i_empty,
    input  wire logic [31:0] i_data,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [7:0] o_result
);

    logic               w_en;
    logic               r_b1_valid;
    logic               r_b1_sat;
    logic signed [63:0] r_b1_prod;
    logic               r_b2_valid;
    logic signed [31:0] r_b2_high;
    logic               r_out_valid;
    logic signed [7:0]  r_result;

    logic signed [63:0] w_round;
    logic [5:0]         w_neg_exp;
    logic [4:0]         w_rsh;
    logic signed [31:0] w_shifted;
    logic signed [32:0] w_biased;
    logic signed [32:0] w_lo_clamped;
    logic signed [32:0] w_clamped;

    // whole pipe advances together whenever the output register can move
    assign w_en  = !r_out_valid || !i_stall;
    assign o_pop = w_en && !i_empty;

    // round-to-nearest high half; both signs reduce to floor((p + 2^30) / 2^31)
    assign w_round = r_b1_prod + idmr_pkg::ROUND_HALF;

    // exponent -32 saturates to a right shift of 31
    assign w_neg_exp = 6'(-i_cfg.expo);
    assign w_rsh     = w_neg_exp[5] ? 5'd31 : w_neg_exp[4:0];
    assign w_shifted = (i_cfg.expo > 6'sd0) ? (r_b2_high <<  i_cfg.expo[4:0])
                                            : (r_b2_high >>> w_rsh);

    // limits are int8, so clamping to them also keeps the value in -128..127
    assign w_biased     = 33'(w_shifted) + 33'(i_cfg.out_off);
    assign w_lo_clamped = (w_biased < 33'(i_cfg.act_lo)) ? 33'(i_cfg.act_lo) : w_biased;
    assign w_clamped    = (w_lo_clamped > 33'(i_cfg.act_hi)) ? 33'(i_cfg.act_hi)
                                                             : w_lo_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_b1_valid  <= !i_empty;
            r_b2_valid  <= r_b1_valid;
            r_out_valid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_prod <= $signed(i_data) * i_cfg.mult;
            r_b1_sat  <= ($signed(i_data) == idmr_pkg::WORD_MIN) &&
                         (i_cfg.mult == idmr_pkg::WORD_MIN);
            r_b2_high <= r_b1_sat ? idmr_pkg::WORD_MAX : w_round[62:31];
            r_result  <= w_clamped[7:0];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

>>> tb/int8_dense_mac_requantize_top_test.sv
`timescale 1ns / 1ps
`default_nettype none
module int8_dense_mac_requantize_top_test;

    localparam logic [idmr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE6 = 3'd6;
    localparam logic [idmr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE7 = 3'd7;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic signed [7:0]  act;
        logic signed [7:0]  wgt;
        logic signed [31:0] bias;
        logic               last;
    } t_mac_beat;

    logic                        i_clk;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    wire logic                   o_stall;
    logic signed [7:0]           i_activation = '0;
    logic signed [7:0]           i_weight = '0;
    logic signed [31:0]          i_bias = '0;
    logic                        i_last = 1'b0;
    wire logic                   o_valid;
    logic                        i_stall = 1'b0;
    wire logic signed [7:0]      o_result;
    logic                        i_cfg_valid = 1'b0;
    wire logic                   o_cfg_ready;
    logic [idmr_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [idmr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    int8_dense_mac_requantize_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_activation (i_activation),
        .i_weight     (i_weight),
        .i_bias       (i_bias),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // shadow copy of the block: registers and dot product accumulator
    idmr_pkg::t_cfg     reg_shadow = '{in_off: idmr_pkg::RST_IN_OFF,
                                       out_off: idmr_pkg::RST_OUT_OFF,
                                       mult: idmr_pkg::RST_MULT,
                                       expo: idmr_pkg::RST_EXPO,
                                       act_lo: idmr_pkg::RST_ACT_LO,
                                       act_hi: idmr_pkg::RST_ACT_HI};
    logic signed [31:0] acc_shadow = '0;

    t_mac_beat          feed_q[$];
    logic signed [7:0]  unit_result_q[$];
    t_mac_beat          cur_beat;
    bit                 no_gaps = 1'b0;
    int                 fail_cnt = 0;
    int                 beats_in = 0;
    int                 units_checked = 0;
    int                 settings_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic signed [31:0] q31_high_mul(logic signed [31:0] a,
                                                        logic signed [31:0] b);
        longint p;
        longint nudge;
        longint q;
        if (a == idmr_pkg::WORD_MIN && b == idmr_pkg::WORD_MIN)
            return idmr_pkg::WORD_MAX;
        p = longint'(a) * longint'(b);
        nudge = (p >= 0) ? (64'sd1 <<< 30) : (64'sd1 - (64'sd1 <<< 30));
        q = (p + nudge) / (64'sd1 <<< 31);
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] pow2_scale(logic signed [31:0] x,
                                                      logic signed [5:0] e);
        int en;
        int n;
        en = int'(e);
        if (en > 0)
            return x << en;
        n = -en;
        if (n > 31)
            n = 31;    // the -32 pattern acts as a shift by 31
        return x >>> n;
    endfunction

    task automatic mac_requant_accept(input t_mac_beat b);
        int                 prod;
        logic signed [31:0] hm;
        longint             v;
        prod = (int'(b.act) + int'(reg_shadow.in_off)) * int'(b.wgt);
        acc_shadow = acc_shadow + prod;
        if (b.last) begin
            acc_shadow = acc_shadow + b.bias;
            hm = q31_high_mul(acc_shadow, reg_shadow.mult);
            v = longint'(pow2_scale(hm, reg_shadow.expo)) + longint'(reg_shadow.out_off);
            if (v < longint'(reg_shadow.act_lo)) v = longint'(reg_shadow.act_lo);
            if (v > longint'(reg_shadow.act_hi)) v = longint'(reg_shadow.act_hi);
            if (v < -128) v = -128;
            if (v > 127) v = 127;
            unit_result_q.push_back(v[7:0]);
            acc_shadow = '0;
        end
    endtask

    // input driver: holds a stalled beat, otherwise presents the next one or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                mac_requant_accept(cur_beat);
                beats_in++;
            end
            if (!i_valid || !o_stall) begin
                if (feed_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 26)) begin
                    cur_beat = feed_q.pop_front();
                    i_activation <= cur_beat.act;
                    i_weight     <= cur_beat.wgt;
                    i_bias       <= cur_beat.bias;
                    i_last       <= cur_beat.last;
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_stall <= !no_gaps && ($urandom_range(0, 99) < 26);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (unit_result_q.size() == 0) begin
                $error("result: expected none, actual %0d", o_result);
                fail_cnt++;
            end else begin
                if (o_result !== unit_result_q[0]) begin
                    $error("result: expected %0d, actual %0d", unit_result_q[0], o_result);
                    fail_cnt++;
                end
                void'(unit_result_q.pop_front());
                units_checked++;
            end
        end
    end

    task automatic write_reg(input logic [idmr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            idmr_pkg::CFG_IN_OFF:  reg_shadow.in_off  = data[8:0];
            idmr_pkg::CFG_OUT_OFF: reg_shadow.out_off = data[7:0];
            idmr_pkg::CFG_MULT:    reg_shadow.mult    = data;
            idmr_pkg::CFG_EXPO:    reg_shadow.expo    = data[5:0];
            idmr_pkg::CFG_ACT_LO:  reg_shadow.act_lo  = data[7:0];
            idmr_pkg::CFG_ACT_HI:  reg_shadow.act_hi  = data[7:0];
            default: ;
        endcase
    endtask

    // wait until every beat is in and every result out, then let the pipe settle
    task automatic drain_pipe();
        @(negedge i_clk);
        while (feed_q.size() != 0 || i_valid || unit_result_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_beat(input logic signed [7:0] act, input logic signed [7:0] wgt,
                             input logic signed [31:0] bias, input logic last);
        t_mac_beat b;
        b.act  = act;
        b.wgt  = wgt;
        b.bias = bias;
        b.last = last;
        feed_q.push_back(b);
    endtask

    // bits above the register width are don't-care: fill them at random half the time
    function automatic logic [31:0] mix_upper(int v, int w);
        logic [31:0] m;
        m = (32'h1 << w) - 32'h1;
        if (w < 32 && $urandom_range(0, 1))
            return (32'(v) & m) | ($urandom() & ~m);
        return 32'(v);
    endfunction

    function automatic logic signed [7:0] rand_operand();
        if ($urandom_range(0, 99) < 15)
            return $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
        return 8'($urandom());
    endfunction

    task automatic random_setup(input bit wild);
        int          v;
        logic [31:0] mult;
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE6 : CFG_IDX_SPARE7, $urandom());

        v = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 255 : -255)
                                        : int'($urandom_range(0, 510)) - 255;
        write_reg(idmr_pkg::CFG_IN_OFF, mix_upper(v, 9));

        v = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 127 : -128)
                                        : int'($urandom_range(0, 255)) - 128;
        write_reg(idmr_pkg::CFG_OUT_OFF, mix_upper(v, 8));

        if (wild) begin
            case ($urandom_range(0, 4))
                0: mult = idmr_pkg::WORD_MIN;
                1: mult = idmr_pkg::WORD_MAX;
                2: mult = $urandom_range(0, 1);
                default: mult = $urandom();
            endcase
        end else begin
            mult = $urandom_range(32'h7fff_ffff, 32'h4000_0000);
            if ($urandom_range(0, 4) == 0)
                mult = -mult;
        end
        write_reg(idmr_pkg::CFG_MULT, mult);

        if (wild)
            v = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 31 : -31)
                                            : int'($urandom_range(0, 63));
        else
            v = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 3))
                                            : -int'($urandom_range(0, 14));
        write_reg(idmr_pkg::CFG_EXPO, mix_upper(v, 6));

        if (wild || $urandom_range(0, 3) == 0) begin
            write_reg(idmr_pkg::CFG_ACT_LO, mix_upper(int'($urandom_range(0, 255)), 8));
            write_reg(idmr_pkg::CFG_ACT_HI, mix_upper(int'($urandom_range(0, 255)), 8));
        end else begin
            v = $urandom_range(0, 1) ? -128 : -int'($urandom_range(0, 128));
            write_reg(idmr_pkg::CFG_ACT_LO, mix_upper(v, 8));
            v = $urandom_range(0, 1) ? 127 : int'($urandom_range(0, 127));
            write_reg(idmr_pkg::CFG_ACT_HI, mix_upper(v, 8));
        end
        settings_cnt++;
    endtask

    initial begin
        int ph;
        int n;
        int len;
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // defaults after reset: extreme operands, ignored bias, extreme bias values
        settings_cnt++;
        @(negedge i_clk);
        push_beat(8'sd127, 8'sd127, 32'sd0, 1'b1);
        push_beat(-8'sd128, -8'sd128, idmr_pkg::WORD_MAX, 1'b0);
        push_beat(-8'sd128, 8'sd127, 32'sd0, 1'b0);
        push_beat(8'sd127, -8'sd128, idmr_pkg::WORD_MAX, 1'b1);
        push_beat(8'sd0, 8'sd0, idmr_pkg::WORD_MIN, 1'b1);
        push_beat(-8'sd1, 8'sd1, -32'sd1, 1'b1);
        drain_pipe();

        // MIN * MIN saturates in the high multiply
        write_reg(idmr_pkg::CFG_MULT, idmr_pkg::WORD_MIN);
        settings_cnt++;
        @(negedge i_clk);
        push_beat(8'sd0, 8'sd0, idmr_pkg::WORD_MIN, 1'b1);
        push_beat(8'sd3, -8'sd7, 32'sd100, 1'b1);
        drain_pipe();

        // exponent pattern -32 gives only the sign
        write_reg(idmr_pkg::CFG_MULT, idmr_pkg::WORD_MAX);
        write_reg(idmr_pkg::CFG_EXPO, -32);
        write_reg(idmr_pkg::CFG_OUT_OFF, -128);
        settings_cnt++;
        @(negedge i_clk);
        push_beat(-8'sd128, 8'sd127, 32'sd0, 1'b1);
        push_beat(8'sd127, 8'sd127, 32'sd5, 1'b1);
        drain_pipe();

        // left shift by 31, extreme offsets, crossed clamp limits
        write_reg(idmr_pkg::CFG_MULT, idmr_pkg::RST_MULT);
        write_reg(idmr_pkg::CFG_EXPO, 31);
        write_reg(idmr_pkg::CFG_IN_OFF, 255);
        write_reg(idmr_pkg::CFG_OUT_OFF, 127);
        write_reg(idmr_pkg::CFG_ACT_LO, 10);
        write_reg(idmr_pkg::CFG_ACT_HI, -10);
        settings_cnt++;
        @(negedge i_clk);
        push_beat(8'sd127, 8'sd127, 32'sd0, 1'b1);
        push_beat(-8'sd128, -8'sd128, -32'sd5, 1'b0);
        push_beat(8'sd0, 8'sd1, 32'sd7, 1'b1);
        drain_pipe();

        // writes to unused indexes must leave the registers alone
        write_reg(idmr_pkg::CFG_IN_OFF, -255);
        write_reg(idmr_pkg::CFG_EXPO, -31);
        write_reg(idmr_pkg::CFG_OUT_OFF, 0);
        write_reg(idmr_pkg::CFG_ACT_LO, -128);
        write_reg(idmr_pkg::CFG_ACT_HI, 127);
        write_reg(idmr_pkg::CFG_MULT, -1);
        write_reg(CFG_IDX_SPARE6, 32'hffff_ffff);
        write_reg(CFG_IDX_SPARE7, 32'h0);
        settings_cnt++;
        @(negedge i_clk);
        push_beat(-8'sd128, -8'sd128, 32'sd0, 1'b1);
        push_beat(8'sd127, 8'sd127, idmr_pkg::WORD_MIN, 1'b1);
        push_beat(8'sd1, 8'sd1, 32'sd1, 1'b1);
        drain_pipe();

        // moderate setting, multi-beat unit
        write_reg(idmr_pkg::CFG_EXPO, -8);
        write_reg(idmr_pkg::CFG_MULT, 32'h5a5a_5a5a);
        write_reg(idmr_pkg::CFG_ACT_LO, -100);
        write_reg(idmr_pkg::CFG_ACT_HI, 100);
        write_reg(idmr_pkg::CFG_OUT_OFF, -3);
        settings_cnt++;
        @(negedge i_clk);
        push_beat(8'sd100, -8'sd50, 32'sd12345, 1'b0);
        push_beat(-8'sd77, 8'sd33, 32'sd0, 1'b0);
        push_beat(8'sd64, 8'sd64, -32'sd2000, 1'b1);
        drain_pipe();

        for (ph = 0; ph < 14; ph++) begin
            random_setup(ph % 3 == 2);
            @(negedge i_clk);
            no_gaps = (ph == 6);
            n = 0;
            while (n < 125) begin
                len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(7, 40))
                                                   : int'($urandom_range(1, 6));
                for (k = 0; k < len; k++) begin
                    if (k == len - 1)
                        push_beat(rand_operand(), rand_operand(),
                                  ($urandom_range(0, 4) == 0) ? $urandom()
                                  : 32'(int'($urandom_range(0, 40000)) - 20000), 1'b1);
                    else
                        push_beat(rand_operand(), rand_operand(), $urandom(), 1'b0);
                end
                n += len;
            end
            // sometimes leave a unit open so the sum carries into the next setting
            if ($urandom_range(0, 3) == 0)
                for (k = 0; k < int'($urandom_range(1, 4)); k++)
                    push_beat(rand_operand(), rand_operand(), $urandom(), 1'b0);
            drain_pipe();
            no_gaps = 1'b0;
        end

        drain_pipe();
        $display("Run covered %0d MAC beats and %0d requantized units over %0d settings.",
                 beats_in, units_checked, settings_cnt);
        $display("Settings included saturation, exponents -32/-31/31, crossed limits.");
        if (fail_cnt == 0 && unit_result_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
